FILE: rtl/hah_pkg.sv
// ----------------------------------------------------------------------------
// hah_pkg
// Shared types and constants for the harmonic alarm with hysteresis:
// fixed point widths, item structs, event codes and register indexes.
// ----------------------------------------------------------------------------
package hah_pkg;

    // fixed point format of confidences and of the averaging weight
    localparam int CONF_BITS = 16;
    localparam int ALPHA_W   = CONF_BITS + 1;
    localparam int PROD_W    = ALPHA_W + CONF_BITS;

    // field widths
    localparam int RMS_W   = 24;
    localparam int BIN_W   = 10;
    localparam int EBIN_W  = 8;
    localparam int COUNT_W = 8;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // event codes carried with each result
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ALARM = 2'd1,
        EV_CLEAR = 2'd2
    } t_event_code;

    // register indexes, byte address is four times the index
    typedef enum logic [2:0] {
        REG_EMA_ALPHA   = 3'd0,
        REG_CONF_ON     = 3'd1,
        REG_CONF_OFF    = 3'd2,
        REG_CONF_CAP    = 3'd3,
        REG_RMS_GATE    = 3'd4,
        REG_SUSTAIN_ON  = 3'd5,
        REG_SUSTAIN_OFF = 3'd6
    } t_reg_idx;

    // one analysis frame
    typedef struct packed {
        logic [RMS_W-1:0]     frame_rms;
        logic                 harmonics_found;
        logic [CONF_BITS-1:0] confidence;
        logic [BIN_W-1:0]     peak_bin;
    } t_in_item;

    // one result per frame
    typedef struct packed {
        t_event_code          event_code;
        logic [CONF_BITS-1:0] event_ratio;
        logic [EBIN_W-1:0]    event_bin;
        logic [RMS_W-1:0]     event_rms;
        logic                 alarm_active;
        logic [CONF_BITS-1:0] conf_level;
    } t_out_item;

endpackage

FILE: rtl/harmonic_alarm_hysteresis.sv
// ----------------------------------------------------------------------------
// harmonic_alarm_hysteresis
// Averages per-frame harmonic confidence and raises or clears an alarm
// through sustain counters on separate on and off thresholds.
// ----------------------------------------------------------------------------
// The block takes one frame per clock while the output is not stalled and
// gives one result per frame through the input and result registers. The
// first stage registers the frame with its silence flag and the weighted new
// confidence (one 17x16 multiply); the second stage closes the average
// recurrence through the decay multiply and an add, then runs the threshold
// compares and sustain counters, all in the same cycle. The user must write
// configuration registers through the APB port only while no frame is in
// flight, which the block leaves to the user. No start-up pass follows reset.
module harmonic_alarm_hysteresis
    import hah_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // frame input
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    // result output
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam logic [ALPHA_W-1:0] Q_ONE     = {1'b1, {CONF_BITS{1'b0}}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [EBIN_W-1:0]  BIN_CAP   = '1;

    // configuration registers
    logic [ALPHA_W-1:0]   r_alpha;
    logic [CONF_BITS-1:0] r_conf_on;
    logic [CONF_BITS-1:0] r_conf_off;
    logic [CONF_BITS-1:0] r_conf_cap;
    logic [RMS_W-1:0]     r_rms_gate;
    logic [COUNT_W-1:0]   r_sus_on;
    logic [COUNT_W-1:0]   r_sus_off;

    // input stage
    logic                 r_in_vld;
    t_in_item             r_in;
    logic                 r_in_silent;
    logic [PROD_W-1:0]    r_in_wc;

    // result stage
    logic                 r_out_vld;
    t_out_item            r_out;

    // detector state
    logic [CONF_BITS-1:0] r_avg;
    logic [COUNT_W-1:0]   r_rise;
    logic [COUNT_W-1:0]   r_fall;
    logic                 r_alarm;

    logic [CONF_BITS-1:0] n_avg;
    logic [COUNT_W-1:0]   n_rise;
    logic [COUNT_W-1:0]   n_fall;
    logic                 n_alarm;
    t_out_item            n_out;

    logic                 out_adv;
    logic                 in_adv;
    logic [ALPHA_W-1:0]   alpha_sat;
    logic [ALPHA_W-1:0]   keep;
    logic [CONF_BITS-1:0] conf_capped;
    logic [PROD_W-1:0]    n_in_wc;
    logic [PROD_W-1:0]    decay;
    logic [PROD_W-1:0]    avg_sum;
    logic [COUNT_W-1:0]   on_need;
    logic [COUNT_W-1:0]   off_need;
    logic [COUNT_W-1:0]   rise_inc;
    logic [COUNT_W-1:0]   fall_inc;
    logic                 cfg_wr;
    t_reg_idx             cfg_idx;

    // handshake: result register frees up when empty or taken
    assign out_adv    = !r_out_vld || !i_out_stall;
    assign in_adv     = !r_in_vld || out_adv;
    assign o_in_stall = !in_adv;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // weight saturation, values above one act as one
    assign alpha_sat = (r_alpha > Q_ONE) ? Q_ONE : r_alpha;
    assign keep      = Q_ONE - alpha_sat;

    // capped confidence weighted by alpha, zero on a silent frame
    always_comb begin
        conf_capped = i_in_data.confidence;
        if (!i_in_data.harmonics_found && (i_in_data.confidence > r_conf_cap)) begin
            conf_capped = r_conf_cap;
        end
        n_in_wc = PROD_W'(alpha_sat) * PROD_W'(conf_capped);
        if (i_in_data.frame_rms < r_rms_gate) begin
            n_in_wc = '0;
        end
    end

    // average update, sum stays below 2^(2*CONF_BITS)
    assign decay   = PROD_W'(keep) * PROD_W'(r_avg);
    assign avg_sum = decay + r_in_wc;

    // sustain needs, zero acts as one
    assign on_need  = (r_sus_on  == '0) ? COUNT_W'(1) : r_sus_on;
    assign off_need = (r_sus_off == '0) ? COUNT_W'(1) : r_sus_off;
    assign rise_inc = (r_rise == COUNT_MAX) ? COUNT_MAX : r_rise + COUNT_W'(1);
    assign fall_inc = (r_fall == COUNT_MAX) ? COUNT_MAX : r_fall + COUNT_W'(1);

    // hysteresis decision for the frame in the input stage
    always_comb begin
        n_avg   = avg_sum[2*CONF_BITS-1:CONF_BITS];
        n_rise  = r_rise;
        n_fall  = r_fall;
        n_alarm = r_alarm;
        n_out   = '0;
        if (r_in_silent) begin
            if (r_alarm) begin
                n_fall = fall_inc;
                if (fall_inc >= off_need) begin
                    n_alarm             = 1'b0;
                    n_out.event_code    = EV_CLEAR;
                    n_out.event_rms     = r_in.frame_rms;
                end
            end
        end else if (!r_alarm) begin
            if (r_in.harmonics_found && (n_avg >= r_conf_on)) begin
                n_rise = rise_inc;
                n_fall = '0;
                if (rise_inc >= on_need) begin
                    n_alarm          = 1'b1;
                    n_out.event_code = EV_ALARM;
                    n_out.event_ratio = r_in.confidence;
                    n_out.event_bin  = (r_in.peak_bin > BIN_W'(BIN_CAP)) ?
                                       BIN_CAP : r_in.peak_bin[EBIN_W-1:0];
                    n_out.event_rms  = r_in.frame_rms;
                end
            end else begin
                n_rise = '0;
            end
        end else begin
            if (!r_in.harmonics_found || (n_avg < r_conf_off)) begin
                n_fall = fall_inc;
                n_rise = '0;
                if (fall_inc >= off_need) begin
                    n_alarm           = 1'b0;
                    n_out.event_code  = EV_CLEAR;
                    n_out.event_ratio = r_in.confidence;
                    n_out.event_bin   = EBIN_W'(r_in.harmonics_found);
                    n_out.event_rms   = r_in.frame_rms;
                end
            end else begin
                n_fall = '0;
            end
        end
        n_out.alarm_active = n_alarm;
        n_out.conf_level   = n_avg;
    end

    // pipeline valids and detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_avg     <= '0;
            r_rise    <= '0;
            r_fall    <= '0;
            r_alarm   <= 1'b0;
        end else begin
            if (in_adv) begin
                r_in_vld <= i_in_valid;
            end
            if (out_adv) begin
                r_out_vld <= r_in_vld;
            end
            if (out_adv && r_in_vld) begin
                r_avg   <= n_avg;
                r_rise  <= n_rise;
                r_fall  <= n_fall;
                r_alarm <= n_alarm;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) begin
            r_in        <= i_in_data;
            r_in_silent <= (i_in_data.frame_rms < r_rms_gate);
            r_in_wc     <= n_in_wc;
        end
        if (out_adv && r_in_vld) begin
            r_out <= n_out;
        end
    end

    // configuration writes
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= ALPHA_W'(16384);
            r_conf_on  <= CONF_BITS'(19661);
            r_conf_off <= CONF_BITS'(11796);
            r_conf_cap <= CONF_BITS'(9830);
            r_rms_gate <= RMS_W'(6711);
            r_sus_on   <= COUNT_W'(2);
            r_sus_off  <= COUNT_W'(8);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_EMA_ALPHA:   r_alpha    <= pwdata[ALPHA_W-1:0];
                REG_CONF_ON:     r_conf_on  <= pwdata[CONF_BITS-1:0];
                REG_CONF_OFF:    r_conf_off <= pwdata[CONF_BITS-1:0];
                REG_CONF_CAP:    r_conf_cap <= pwdata[CONF_BITS-1:0];
                REG_RMS_GATE:    r_rms_gate <= pwdata[RMS_W-1:0];
                REG_SUSTAIN_ON:  r_sus_on   <= pwdata[COUNT_W-1:0];
                REG_SUSTAIN_OFF: r_sus_off  <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (cfg_idx)
            REG_EMA_ALPHA:   prdata = DATA_W'(r_alpha);
            REG_CONF_ON:     prdata = DATA_W'(r_conf_on);
            REG_CONF_OFF:    prdata = DATA_W'(r_conf_off);
            REG_CONF_CAP:    prdata = DATA_W'(r_conf_cap);
            REG_RMS_GATE:    prdata = DATA_W'(r_rms_gate);
            REG_SUSTAIN_ON:  prdata = DATA_W'(r_sus_on);
            REG_SUSTAIN_OFF: prdata = DATA_W'(r_sus_off);
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: rtl/hah_checker.sv
// ----------------------------------------------------------------------------
// hah_checker
// Port-level checks on the result stream of the harmonic alarm block.
// ----------------------------------------------------------------------------
module hah_checker
    import hah_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    logic r_last_alarm;
    logic out_xfer;

    assign out_xfer = o_out_valid && !i_out_stall;

    // alarm state shown by the last result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_alarm <= 1'b0;
        end else if (out_xfer) begin
            r_last_alarm <= o_out_data.alarm_active;
        end
    end

    // no result straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // a frame without event leaves the alarm where it was
    a_none_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_out_data.event_code == EV_NONE |->
        o_out_data.alarm_active == r_last_alarm && o_out_data.event_rms == '0)
        else $error("alarm changed without event");

    // raise only from quiet, clear only from alarm
    a_event_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_out_data.event_code != EV_NONE |->
        (o_out_data.event_code == EV_ALARM && !r_last_alarm && o_out_data.alarm_active) ||
        (o_out_data.event_code == EV_CLEAR && r_last_alarm && !o_out_data.alarm_active))
        else $error("event does not match alarm transition");

endmodule

bind harmonic_alarm_hysteresis hah_checker u_hah_checker (.*);
